### rtl/cpc_pkg.sv
package cpc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int SIZE_W          = 15;
  localparam int PEN_W           = 18;
  localparam int NORM_W          = 16;
  localparam int RS_W            = 16;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_BITS        = 15;
  // edges from the accepting edge to the edge at which done is sampled high
  localparam int LATENCY         = 3 + SQRT_STEPS + 1 + DIV_BITS + 1;

  localparam logic [1:0] KIND_CC = 2'd0;
  localparam logic [1:0] KIND_CB = 2'd1;
  localparam logic [1:0] KIND_BB = 2'd2;

  localparam logic signed [NORM_W-1:0] NORM_POS = 16'sd32767;
  localparam logic signed [NORM_W-1:0] NORM_NEG = -16'sd32767;
  localparam logic signed [PEN_W-1:0]  PEN_MAX  = 18'sd131071;
  localparam logic signed [PEN_W-1:0]  PEN_MIN  = -18'sd131072;

  // results that need no root (box pairs and the unused selector), plus the circle flag and radius sum
  typedef struct packed {
    logic                     circ;
    logic                     fhit;
    logic signed [PEN_W-1:0]  fpen;
    logic signed [NORM_W-1:0] fnx;
    logic signed [NORM_W-1:0] fny;
    logic [RS_W-1:0]          rs;
  } cpc_fix_t;

endpackage

### rtl/collision_pair_contact.sv
// Throughput: one pair per cycle while busy is low; busy is a registered copy of rst.
// The depth is set by the 32-cell square root chain and the 15-cell divider chain.
// Reset (rst, synchronous) clears every valid bit in the chain; payload is not reset.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
module collision_pair_contact #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type,
  input  logic signed [COORD_WIDTH-1:0]       a_x,
  input  logic signed [COORD_WIDTH-1:0]       a_y,
  input  logic [cpc_pkg::SIZE_W-1:0]          a_w,
  input  logic [cpc_pkg::SIZE_W-1:0]          a_h,
  input  logic signed [COORD_WIDTH-1:0]       b_x,
  input  logic signed [COORD_WIDTH-1:0]       b_y,
  input  logic [cpc_pkg::SIZE_W-1:0]          b_w,
  input  logic [cpc_pkg::SIZE_W-1:0]          b_h,
  output logic                                done,
  output logic                                hit,
  output logic signed [cpc_pkg::PEN_W-1:0]    pen_depth,
  output logic signed [cpc_pkg::NORM_W-1:0]   normal_x,
  output logic signed [cpc_pkg::NORM_W-1:0]   normal_y,
  output logic                                degenerate
);

  localparam int DW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 3;
  localparam int PW = 2 * DW;
  localparam int FW = $bits(cpc_pkg::cpc_fix_t);
  localparam int SW = FW + 4 + 2 * DW;
  localparam int SW2 = SW + 2;
  localparam int NS = cpc_pkg::SQRT_STEPS;
  localparam int ND = cpc_pkg::DIV_BITS;
  localparam int NORM_W_L = cpc_pkg::NORM_W;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // ---- stage 1: direction, box results
  logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic signed [DW-1:0] tx, ty, dx, dy, ddx, ddy, adx, ady, ox, oy;
  logic                 sx_c, sy_c;
  logic [DW-1:0]        ux_c, uy_c;
  cpc_pkg::cpc_fix_t    fix_c;

  always_comb begin
    ax = DW'(a_x);
    ay = DW'(a_y);
    bx = DW'(b_x);
    by = DW'(b_y);
    aw = DW'(a_w);
    ah = DW'(a_h);
    bw = DW'(b_w);
    bh = DW'(b_h);

    tx = ax;
    if (ax < bx) begin
      tx = bx;
    end else if (ax > bx + bw) begin
      tx = bx + bw;
    end
    ty = ay;
    if (ay < by) begin
      ty = by;
    end else if (ay > by + bh) begin
      ty = by + bh;
    end

    if (req_type == cpc_pkg::KIND_CC) begin
      dx = bx - ax;
      dy = by - ay;
    end else begin
      dx = tx - ax;
      dy = ty - ay;
    end
    sx_c = dx[DW-1];
    sy_c = dy[DW-1];
    ux_c = sx_c ? DW'(-dx) : DW'(dx);
    uy_c = sy_c ? DW'(-dy) : DW'(dy);

    ddx = ((bx + bx) + bw) - ((ax + ax) + aw);
    ddy = ((by + by) + bh) - ((ay + ay) + ah);
    adx = ddx[DW-1] ? -ddx : ddx;
    ady = ddy[DW-1] ? -ddy : ddy;
    ox  = (aw + bw) - adx;
    oy  = (ah + bh) - ady;

    fix_c = '0;
    case (req_type)
      cpc_pkg::KIND_CC: begin
        fix_c.circ = 1'b1;
        fix_c.rs   = cpc_pkg::RS_W'(a_w) + cpc_pkg::RS_W'(b_w);
      end
      cpc_pkg::KIND_CB: begin
        fix_c.circ = 1'b1;
        fix_c.rs   = cpc_pkg::RS_W'(a_w);
      end
      cpc_pkg::KIND_BB: begin
        fix_c.fhit = (ax + aw >= bx) && (ax <= bx + bw) &&
                     (ay + ah >= by) && (ay <= by + bh);
        if (ox > 0 && oy > 0) begin
          if (ox < oy) begin
            fix_c.fpen = cpc_pkg::PEN_W'(ox >>> 1);
            fix_c.fnx  = (ddx > 0) ? cpc_pkg::NORM_POS : cpc_pkg::NORM_NEG;
          end else begin
            fix_c.fpen = cpc_pkg::PEN_W'(oy >>> 1);
            fix_c.fny  = (ddy > 0) ? cpc_pkg::NORM_POS : cpc_pkg::NORM_NEG;
          end
        end
      end
      default: begin
        fix_c = '0;
      end
    endcase
  end

  logic              s1_valid, s1_sx, s1_sy;
  logic [DW-1:0]     s1_ux, s1_uy;
  cpc_pkg::cpc_fix_t s1_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_sx  <= sx_c;
    s1_sy  <= sy_c;
    s1_ux  <= ux_c;
    s1_uy  <= uy_c;
    s1_fix <= fix_c;
  end

  // ---- stage 2: squares
  logic              s2_valid, s2_sx, s2_sy;
  logic [DW-1:0]     s2_ux, s2_uy;
  logic [PW-1:0]     s2_px, s2_py;
  logic [2*cpc_pkg::RS_W-1:0] s2_rr;
  cpc_pkg::cpc_fix_t s2_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sx  <= s1_sx;
    s2_sy  <= s1_sy;
    s2_ux  <= s1_ux;
    s2_uy  <= s1_uy;
    s2_px  <= PW'(s1_ux) * PW'(s1_ux);
    s2_py  <= PW'(s1_uy) * PW'(s1_uy);
    s2_rr  <= (2*cpc_pkg::RS_W)'(s1_fix.rs) * (2*cpc_pkg::RS_W)'(s1_fix.rs);
    s2_fix <= s1_fix;
  end

  // ---- stage 3: squared length, circle overlap test
  logic [63:0] d2;
  assign d2 = 64'(s2_px) + 64'(s2_py);

  logic          s3_valid;
  logic [63:0]   s3_x;
  logic [SW-1:0] s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_x    <= d2 << 16;
    s3_side <= {s2_fix, s2_sx, s2_sy, (d2 <= 64'(s2_rr)), (d2 == 64'd0), s2_ux, s2_uy};
  end

  // ---- square root chain, one result bit per cell
  logic          sq_valid [0:NS];
  logic [63:0]   sq_x     [0:NS];
  logic [63:0]   sq_res   [0:NS];
  logic [SW-1:0] sq_side  [0:NS];

  assign sq_valid[0] = s3_valid;
  assign sq_x[0]     = s3_x;
  assign sq_res[0]   = 64'd0;
  assign sq_side[0]  = s3_side;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    cpc_sqrt_cell #(.STEP(i), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_valid[i]),
      .in_x     (sq_x[i]),
      .in_res   (sq_res[i]),
      .in_side  (sq_side[i]),
      .out_valid(sq_valid[i+1]),
      .out_x    (sq_x[i+1]),
      .out_res  (sq_res[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // ---- quotient overflow check
  logic [DW-1:0] o_ux, o_uy;
  logic [31:0]   o_l;
  logic [63:0]   num_x, num_y, lim;

  always_comb begin
    o_uy  = sq_side[NS][DW-1:0];
    o_ux  = sq_side[NS][2*DW-1:DW];
    o_l   = sq_res[NS][31:0];
    num_x = 64'(o_ux) << 23;
    num_y = 64'(o_uy) << 23;
    lim   = 64'(o_l) << ND;
  end

  logic           ov_valid;
  logic [63:0]    ov_rem_x, ov_rem_y;
  logic [31:0]    ov_l;
  logic [SW2-1:0] ov_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov_valid <= 1'b0;
    end else begin
      ov_valid <= sq_valid[NS];
    end
    ov_rem_x <= num_x;
    ov_rem_y <= num_y;
    ov_l     <= o_l;
    ov_side  <= {(num_x >= lim), (num_y >= lim), sq_side[NS]};
  end

  // ---- restoring divider chain, one quotient bit per cell
  logic           dv_valid [0:ND];
  logic [63:0]    dv_rem_x [0:ND];
  logic [63:0]    dv_rem_y [0:ND];
  logic [31:0]    dv_l     [0:ND];
  logic [ND-1:0]  dv_qx    [0:ND];
  logic [ND-1:0]  dv_qy    [0:ND];
  logic [SW2-1:0] dv_side  [0:ND];

  assign dv_valid[0] = ov_valid;
  assign dv_rem_x[0] = ov_rem_x;
  assign dv_rem_y[0] = ov_rem_y;
  assign dv_l[0]     = ov_l;
  assign dv_qx[0]    = '0;
  assign dv_qy[0]    = '0;
  assign dv_side[0]  = ov_side;

  for (genvar j = 0; j < ND; j++) begin : g_div
    cpc_div_cell #(.SH(ND - 1 - j), .SW(SW2)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_valid[j]),
      .in_rem_x (dv_rem_x[j]),
      .in_rem_y (dv_rem_y[j]),
      .in_l     (dv_l[j]),
      .in_qx    (dv_qx[j]),
      .in_qy    (dv_qy[j]),
      .in_side  (dv_side[j]),
      .out_valid(dv_valid[j+1]),
      .out_rem_x(dv_rem_x[j+1]),
      .out_rem_y(dv_rem_y[j+1]),
      .out_l    (dv_l[j+1]),
      .out_qx   (dv_qx[j+1]),
      .out_qy   (dv_qy[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  // ---- result assembly
  cpc_pkg::cpc_fix_t        f_fix;
  logic                     f_satx, f_saty, f_sx, f_sy, f_hit, f_deg;
  logic [NORM_W_L-1:0]      f_mx, f_my;
  logic [23:0]              f_dist;
  logic signed [25:0]       f_diff;
  logic signed [cpc_pkg::PEN_W-1:0]  f_pen;
  logic signed [cpc_pkg::NORM_W-1:0] f_nx, f_ny;

  always_comb begin
    f_satx = dv_side[ND][SW2-1];
    f_saty = dv_side[ND][SW2-2];
    {f_fix, f_sx, f_sy, f_hit, f_deg} = dv_side[ND][SW-1:2*DW];
    f_mx   = f_satx ? NORM_W_L'(cpc_pkg::NORM_POS) : {1'b0, dv_qx[ND]};
    f_my   = f_saty ? NORM_W_L'(cpc_pkg::NORM_POS) : {1'b0, dv_qy[ND]};
    f_dist = f_deg ? 24'd0 : dv_l[ND][31:8];
    f_diff = $signed({10'd0, f_fix.rs}) - $signed({2'd0, f_dist});
    if (f_diff > 26'(cpc_pkg::PEN_MAX)) begin
      f_pen = cpc_pkg::PEN_MAX;
    end else if (f_diff < 26'(cpc_pkg::PEN_MIN)) begin
      f_pen = cpc_pkg::PEN_MIN;
    end else begin
      f_pen = cpc_pkg::PEN_W'(f_diff);
    end
    if (f_deg) begin
      f_nx = '0;
      f_ny = '0;
    end else begin
      f_nx = f_sx ? -$signed(f_mx) : $signed(f_mx);
      f_ny = f_sy ? -$signed(f_my) : $signed(f_my);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[ND];
    end
    if (f_fix.circ) begin
      hit        <= f_hit;
      pen_depth  <= f_pen;
      normal_x   <= f_nx;
      normal_y   <= f_ny;
      degenerate <= f_deg;
    end else begin
      hit        <= f_fix.fhit;
      pen_depth  <= f_fix.fpen;
      normal_x   <= f_fix.fnx;
      normal_y   <= f_fix.fny;
      degenerate <= 1'b0;
    end
  end

endmodule

### rtl/cpc_sqrt_cell.sv
module cpc_sqrt_cell #(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   in_x,
  input  logic [63:0]   in_res,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [63:0]   out_x,
  output logic [63:0]   out_res,
  output logic [SW-1:0] out_side
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic [63:0] x_next;
  logic [63:0] res_next;

  always_comb begin
    trial = in_res + BIT;
    if (in_x >= trial) begin
      x_next   = in_x - trial;
      res_next = (in_res >> 1) + BIT;
    end else begin
      x_next   = in_x;
      res_next = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_x    <= x_next;
    out_res  <= res_next;
    out_side <= in_side;
  end

endmodule

### rtl/cpc_div_cell.sv
module cpc_div_cell #(
  parameter int SH = 0,
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [63:0]                  in_rem_x,
  input  logic [63:0]                  in_rem_y,
  input  logic [31:0]                  in_l,
  input  logic [cpc_pkg::DIV_BITS-1:0] in_qx,
  input  logic [cpc_pkg::DIV_BITS-1:0] in_qy,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [63:0]                  out_rem_x,
  output logic [63:0]                  out_rem_y,
  output logic [31:0]                  out_l,
  output logic [cpc_pkg::DIV_BITS-1:0] out_qx,
  output logic [cpc_pkg::DIV_BITS-1:0] out_qy,
  output logic [SW-1:0]                out_side
);

  logic [63:0]                  dsh;
  logic [63:0]                  rem_x_next;
  logic [63:0]                  rem_y_next;
  logic [cpc_pkg::DIV_BITS-1:0] qx_next;
  logic [cpc_pkg::DIV_BITS-1:0] qy_next;

  always_comb begin
    dsh        = 64'(in_l) << SH;
    rem_x_next = in_rem_x;
    rem_y_next = in_rem_y;
    qx_next    = in_qx;
    qy_next    = in_qy;
    if (in_rem_x >= dsh) begin
      rem_x_next  = in_rem_x - dsh;
      qx_next[SH] = 1'b1;
    end
    if (in_rem_y >= dsh) begin
      rem_y_next  = in_rem_y - dsh;
      qy_next[SH] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem_x <= rem_x_next;
    out_rem_y <= rem_y_next;
    out_l     <= in_l;
    out_qx    <= qx_next;
    out_qy    <= qy_next;
    out_side  <= in_side;
  end

endmodule

### rtl/cpc_checker.sv
module cpc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic                                degenerate,
  input logic signed [cpc_pkg::NORM_W-1:0]   normal_x,
  input logic signed [cpc_pkg::NORM_W-1:0]   normal_y
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(cpc_pkg::LATENCY) done)
    else $error("result beat missing after accepted pair");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##(cpc_pkg::LATENCY) !done)
    else $error("result beat without accepted pair");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0)
    else $error("degenerate result with nonzero normal");

endmodule

bind collision_pair_contact cpc_checker u_cpc_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] ax, ay, bx, by;
    logic [14:0]        aw, ah, bw, bh;
  } pair_t;

  typedef struct {
    logic               hit;
    logic signed [17:0] pen;
    logic signed [15:0] nx, ny;
    logic               degen;
  } contact_t;

  // directed rows; known says the typed-in result applies
  typedef struct {
    pair_t    p;
    bit       known;
    contact_t r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] req_type = 0;
  logic signed [15:0] a_x = 0, a_y = 0, b_x = 0, b_y = 0;
  logic [14:0] a_w = 0, a_h = 0, b_w = 0, b_h = 0;
  logic done, hit, degenerate;
  logic signed [17:0] pen_depth;
  logic signed [15:0] normal_x, normal_y;

  contact_t contact_q[$];
  int errors = 0, checked = 0, sent = 0, hits = 0, degens = 0;
  longint cycles = 0;
  int kind_cnt[4];

  always #6 clk = ~clk;

  collision_pair_contact dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .a_x(a_x), .a_y(a_y), .a_w(a_w), .a_h(a_h),
    .b_x(b_x), .b_y(b_y), .b_w(b_w), .b_h(b_h),
    .done(done), .hit(hit), .pen_depth(pen_depth), .normal_x(normal_x),
    .normal_y(normal_y), .degenerate(degenerate)
  );

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_pen(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint unit_comp(longint d, longint unsigned l);
    longint unsigned m;
    m = ((d < 0 ? -d : d) << 23) / l;
    if (m > 32767) m = 32767;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  // shared by both circle cases: fills hit, normal and degenerate flag, returns depth before clamp
  function automatic longint circle_contact(longint dx, longint dy, longint rad,
                                            inout contact_t c);
    longint unsigned d2, l;
    d2 = dx * dx + dy * dy;
    l = floor_root(d2 << 16);
    c.hit = d2 <= rad * rad;
    if (d2 == 0 || l == 0) begin
      c.degen = 1;
      return rad - longint'(floor_root(d2));
    end
    c.nx = 16'(unit_comp(dx, l));
    c.ny = 16'(unit_comp(dy, l));
    return rad - longint'(l >> 8);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint ax, ay, bx, by, aw, ah, bw, bh, tx, ty, ddx, ddy, ox, oy;
    c = '{default: 0};
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    aw = p.aw; ah = p.ah; bw = p.bw; bh = p.bh;
    case (p.kind)
      cpc_pkg::KIND_CC: c.pen = 18'(clamp_pen(circle_contact(bx - ax, by - ay, aw + bw, c)));
      cpc_pkg::KIND_CB: begin
        tx = ax; ty = ay;
        if (ax < bx) tx = bx; else if (ax > bx + bw) tx = bx + bw;
        if (ay < by) ty = by; else if (ay > by + bh) ty = by + bh;
        c.pen = 18'(clamp_pen(circle_contact(tx - ax, ty - ay, aw, c)));
      end
      cpc_pkg::KIND_BB: begin
        ddx = (2 * bx + bw) - (2 * ax + aw);
        ddy = (2 * by + bh) - (2 * ay + ah);
        ox = (aw + bw) - (ddx < 0 ? -ddx : ddx);
        oy = (ah + bh) - (ddy < 0 ? -ddy : ddy);
        c.hit = (ax + aw >= bx) && (ax <= bx + bw) && (ay + ah >= by) && (ay <= by + bh);
        if (ox > 0 && oy > 0) begin
          if (ox < oy) begin
            c.pen = 18'(clamp_pen(ox >>> 1));
            c.nx = ddx > 0 ? cpc_pkg::NORM_POS : cpc_pkg::NORM_NEG;
          end else begin
            c.pen = 18'(clamp_pen(oy >>> 1));
            c.ny = ddy > 0 ? cpc_pkg::NORM_POS : cpc_pkg::NORM_NEG;
          end
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // leaves start high; gap() with a nonzero pause or the end of the run drops it
  task automatic send_pair(pair_t p, bit known, contact_t r);
    contact_t e;
    e = known ? r : predict_contact(p);
    req_type <= p.kind;
    a_x <= p.ax; a_y <= p.ay; a_w <= p.aw; a_h <= p.ah;
    b_x <= p.bx; b_y <= p.by; b_w <= p.bw; b_h <= p.bh;
    start <= 1;
    do @(posedge clk); while (busy);
    contact_q.push_back(e);
    sent++;
    kind_cnt[p.kind]++;
    @(negedge clk);
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (n > 0) start <= 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0);
    p.kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    p.ax = rnd_coord(mode); p.ay = rnd_coord(mode);
    p.bx = rnd_coord(mode); p.by = rnd_coord(mode);
    if (mode == 1) begin
      p.aw = 15'($urandom_range(0, 300)); p.ah = 15'($urandom_range(0, 300));
      p.bw = 15'($urandom_range(0, 300)); p.bh = 15'($urandom_range(0, 300));
    end else begin
      p.aw = 15'($urandom); p.ah = 15'($urandom);
      p.bw = 15'($urandom); p.bh = 15'($urandom);
    end
    return p;
  endfunction

  // sample results
  always @(posedge clk) begin
    contact_t e;
    if (!rst && done) begin
      if (contact_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat with nothing expected");
      end else begin
        e = contact_q.pop_front();
        checked++;
        if (hit) hits++;
        if (degenerate) degens++;
        if (hit !== e.hit || pen_depth !== e.pen || normal_x !== e.nx ||
            normal_y !== e.ny || degenerate !== e.degen) begin
          errors++;
          if (errors <= 10)
            $display("ERROR beat %0d: exp hit %0d pen %0d n %0d,%0d deg %0d; got %0d %0d %0d,%0d %0d",
                     checked, e.hit, e.pen, e.nx, e.ny, e.degen,
                     hit, pen_depth, normal_x, normal_y, degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout with %0d pending", contact_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    contact_t z;
    pair_t p;
    int wait_n;
    z = '{default: 0};
    // unused selector gives all zero
    rows.push_back('{'{2'd3, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                       15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff}, 1, z});
    // coincident circles: degenerate, depth is radius sum
    rows.push_back('{'{cpc_pkg::KIND_CC, 0, 0, 0, 0, 16, 0, 32, 0}, 1,
                     '{1, 18'sd48, 0, 0, 1}});
    rows.push_back('{'{cpc_pkg::KIND_CC, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0, 1}});
    // circle centre inside box
    rows.push_back('{'{cpc_pkg::KIND_CB, 50, 50, 0, 0, 20, 0, 100, 100}, 1,
                     '{1, 18'sd20, 0, 0, 1}});
    // boxes far apart: no depth, no normal
    rows.push_back('{'{cpc_pkg::KIND_BB, -1000, -1000, 1000, 1000, 10, 10, 10, 10}, 1, z});
    // boxes touching on an edge: hit but zero depth
    rows.push_back('{'{cpc_pkg::KIND_BB, 0, 0, 10, 0, 10, 10, 10, 10}, 1,
                     '{1, 0, 0, 0, 0}});
    // identical boxes: tie picks y, centre offset zero gives negative normal
    rows.push_back('{'{cpc_pkg::KIND_BB, 0, 0, 0, 0, 32, 32, 32, 32}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_BB, 0, 0, 10, 0, 32, 64, 32, 64}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_BB, 0, 0, 0, -10, 64, 32, 64, 32}, 0, z});
    // extreme coordinates and sizes, mixed with small offset cases
    rows.push_back('{'{cpc_pkg::KIND_CC, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                       15'h7fff, 0, 15'h7fff, 0}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_CC, 16'sh7fff, 0, 16'sh7fff, 1,
                       15'h7fff, 0, 15'h7fff, 0}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_CC, 0, 0, 16'sh8000, 0, 0, 0, 0, 0}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_CC, 0, 0, 3, -4, 10, 0, 10, 0}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_CB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                       15'h7fff, 0, 15'h7fff, 15'h7fff}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_CB, 16'sh7fff, 16'sh8000, 0, 0, 100, 0, 0, 0}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_CB, -20, 5, 0, 0, 30, 0, 40, 40}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_BB, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                       15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_BB, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                       15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff}, 0, z});
    rows.push_back('{'{cpc_pkg::KIND_BB, 0, 0, 16'sh5555, 16'shaaaa,
                       15'h5555, 15'h2aaa, 15'h2aaa, 15'h5555}, 0, z});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[i]) begin
      send_pair(rows[i].p, rows[i].known, rows[i].r);
      if (i % 3 == 0) gap();
    end
    for (int n = 0; n < 1000; n++) begin
      p = rnd_pair();
      send_pair(p, 0, z);
      gap();
    end
    start <= 0;
    wait_n = 0;
    while (contact_q.size() != 0 && wait_n < 2000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (cpc_pkg::LATENCY + 10) @(posedge clk);
    $display("pairs sent %0d (cc %0d, cb %0d, bb %0d, unused %0d), beats checked %0d",
             sent, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], checked);
    $display("hits %0d, degenerate %0d, mismatches %0d", hits, degens, errors);
    if (errors == 0 && contact_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
